[rtl/y420argb_pkg.sv]
`timescale 1ns / 1ps

package y420argb_pkg;

    localparam logic signed [8:0]  CHROMA_CENTRE = 9'sd128;
    localparam logic signed [11:0] K_CR_R        = 12'sd1436;
    localparam logic signed [11:0] K_CB_G        = 12'sd352;
    localparam logic signed [11:0] K_CR_G        = 12'sd731;
    localparam logic signed [11:0] K_CB_B        = 12'sd1815;
    localparam logic signed [19:0] ROUND_HALF    = 20'sd512;
    localparam logic [7:0]         ALPHA_OPAQUE  = 8'hFF;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic       has_second;
    } t_in_item;

    typedef struct packed {
        logic [31:0] argb_first;
        logic [31:0] argb_second;
        logic        second_valid;
    } t_out_item;

    typedef struct packed {
        logic signed [9:0] red;
        logic signed [9:0] green;
        logic signed [9:0] blue;
    } t_offsets;

endpackage

[rtl/y420argb_offset.sv]
`timescale 1ns / 1ps

module y420argb_offset
    import y420argb_pkg::*;
(
    input  logic [7:0] i_chroma_blue,
    input  logic [7:0] i_chroma_red,
    output t_offsets   o_offsets
);

    logic signed [8:0]  w_cb;
    logic signed [8:0]  w_cr;
    logic signed [19:0] w_sum_red;
    logic signed [19:0] w_sum_green;
    logic signed [19:0] w_sum_blue;

    assign w_cb = $signed({1'b0, i_chroma_blue}) - CHROMA_CENTRE;
    assign w_cr = $signed({1'b0, i_chroma_red}) - CHROMA_CENTRE;

    assign w_sum_red   = K_CR_R * w_cr + ROUND_HALF;
    assign w_sum_green = K_CB_G * w_cb + K_CR_G * w_cr + ROUND_HALF;
    assign w_sum_blue  = K_CB_B * w_cb + ROUND_HALF;

    // Taking the upper bits is a floor division by 1024.
    assign o_offsets.red   = w_sum_red[19:10];
    assign o_offsets.green = w_sum_green[19:10];
    assign o_offsets.blue  = w_sum_blue[19:10];

endmodule

[rtl/y420argb_pack.sv]
`timescale 1ns / 1ps

module y420argb_pack
    import y420argb_pkg::*;
(
    input  logic [7:0]  i_luma,
    input  t_offsets    i_offsets,
    output logic [31:0] o_argb
);

    logic signed [10:0] w_red;
    logic signed [10:0] w_green;
    logic signed [10:0] w_blue;

    function automatic logic [7:0] sat8(input logic signed [10:0] v);
        logic [7:0] res;
        if (v[10]) begin
            res = 8'd0;
        end else if (v[9:8] != 2'b00) begin
            res = 8'hFF;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    assign w_red   = $signed({3'b000, i_luma})
                   + $signed({i_offsets.red[9], i_offsets.red});
    assign w_green = $signed({3'b000, i_luma})
                   - $signed({i_offsets.green[9], i_offsets.green});
    assign w_blue  = $signed({3'b000, i_luma})
                   + $signed({i_offsets.blue[9], i_offsets.blue});

    assign o_argb = {ALPHA_OPAQUE, sat8(w_red), sat8(w_green), sat8(w_blue)};

endmodule

[rtl/ycbcr420_pair_to_argb32_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         start, busy               i_in (t_in_item)
// result    out        o_result_strobe           o_result (t_out_item)
//
// One pixel pair is taken in every cycle; busy is never raised.
// A result passes from its transfer through one input register,
// then the offset and saturation logic, then the result register.
// Reset clears the valid flags only; no state is kept between pairs.
// The receiver cannot stall, so each result is shown for one cycle.

module ycbcr420_pair_to_argb32_core
    import y420argb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_in,
    output t_out_item o_result,
    output logic      o_result_strobe
);

    t_in_item    r_in;
    logic        r_in_valid;
    t_out_item   r_out;
    logic        r_out_valid;
    t_out_item   n_out;
    t_offsets    w_offsets;
    logic [31:0] w_argb_first;
    logic [31:0] w_argb_second;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_in;
        end
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    y420argb_offset u_offset (
        .i_chroma_blue (r_in.chroma_blue),
        .i_chroma_red  (r_in.chroma_red),
        .o_offsets     (w_offsets)
    );

    y420argb_pack u_pack_first (
        .i_luma    (r_in.luma_first),
        .i_offsets (w_offsets),
        .o_argb    (w_argb_first)
    );

    y420argb_pack u_pack_second (
        .i_luma    (r_in.luma_second),
        .i_offsets (w_offsets),
        .o_argb    (w_argb_second)
    );

    always_comb begin
        n_out.argb_first   = w_argb_first;
        n_out.argb_second  = r_in.has_second ? w_argb_second : 32'd0;
        n_out.second_valid = r_in.has_second;
    end

    assign o_result        = r_out;
    assign o_result_strobe = r_out_valid;

endmodule

[dv/tb_ycbcr420_pair_to_argb32_core.sv]
`timescale 1ns / 1ps

module tb_ycbcr420_pair_to_argb32_core;
    import y420argb_pkg::*;

    localparam int RANDOM_PAIRS  = 1700;
    localparam int CALM_TAIL     = 200;
    localparam int DRAIN_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 200000;

    class argb_pair_scoreboard;
        t_out_item expected_pixels[$];
        int        fail_count;

        function new();
            fail_count = 0;
        endfunction

        function logic [7:0] clamp_channel(int value);
            if (value < 0) begin
                return 8'd0;
            end
            if (value > 255) begin
                return 8'd255;
            end
            return value[7:0];
        endfunction

        function logic [31:0] pack_argb(int luma, int dr, int dg, int db);
            return {ALPHA_OPAQUE, clamp_channel(luma + dr), clamp_channel(luma - dg),
                    clamp_channel(luma + db)};
        endfunction

        function t_out_item predict_pixels(t_in_item pair);
            int        cb;
            int        cr;
            int        dr;
            int        dg;
            int        db;
            t_out_item pixels;
            cb = int'(pair.chroma_blue) - int'(CHROMA_CENTRE);
            cr = int'(pair.chroma_red) - int'(CHROMA_CENTRE);
            // Arithmetic shifts on signed ints give the floor that the offsets need.
            dr = (int'(K_CR_R) * cr + int'(ROUND_HALF)) >>> 10;
            dg = (int'(K_CB_G) * cb + int'(K_CR_G) * cr + int'(ROUND_HALF)) >>> 10;
            db = (int'(K_CB_B) * cb + int'(ROUND_HALF)) >>> 10;
            pixels.argb_first   = pack_argb(int'(pair.luma_first), dr, dg, db);
            pixels.argb_second  = pair.has_second ?
                                  pack_argb(int'(pair.luma_second), dr, dg, db) : 32'd0;
            pixels.second_valid = pair.has_second;
            return pixels;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %h, expected %h", what, got, want);
            fail_count++;
        endtask

        function void note_pair(t_in_item pair);
            expected_pixels.push_back(predict_pixels(pair));
        endfunction

        task check_pixels(t_out_item got);
            t_out_item want;
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected result", got.argb_first, 32'd0);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.argb_first !== want.argb_first) begin
                report_mismatch("argb_first", got.argb_first, want.argb_first);
            end
            if (got.argb_second !== want.argb_second) begin
                report_mismatch("argb_second", got.argb_second, want.argb_second);
            end
            if (got.second_valid !== want.second_valid) begin
                report_mismatch("second_valid", 32'(got.second_valid),
                                32'(want.second_valid));
            end
        endtask

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_in;
    t_out_item o_result;
    logic      o_result_strobe;

    argb_pair_scoreboard pixel_board;
    int                  cycle_count;

    ycbcr420_pair_to_argb32_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_in            (i_in),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ycbcr420_pair_to_argb32_core verification failed");
            $finish;
        end
    end

    // A transfer happens at the edge where start is high and busy is low.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
            pixel_board.note_pair(i_in);
        end
        if (i_rst_n === 1'b1 && o_result_strobe === 1'b1) begin
            pixel_board.check_pixels(o_result);
        end
    end

    function automatic t_in_item make_pair(logic [7:0] y0, logic [7:0] y1, logic [7:0] cb,
                                           logic [7:0] cr, logic second);
        t_in_item pair;
        pair.luma_first  = y0;
        pair.luma_second = y1;
        pair.chroma_blue = cb;
        pair.chroma_red  = cr;
        pair.has_second  = second;
        return pair;
    endfunction

    function automatic logic [7:0] random_sample();
        case ($urandom_range(0, 7))
            0: begin
                return 8'd0;
            end
            1: begin
                return 8'd255;
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    function automatic t_in_item random_pair();
        return make_pair(random_sample(), random_sample(), random_sample(), random_sample(),
                         1'($urandom_range(0, 1)));
    endfunction

    task automatic send_pair(t_in_item pair);
        @(negedge i_clk);
        i_in  <= pair;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic idle_cycles(int count);
        repeat (count) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_in  <= t_in_item'({$urandom, 1'($urandom)});
        end
    endtask

    t_in_item directed_pairs[$];

    initial begin
        pixel_board = new();
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_in    = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Neutral chroma, saturation both ways, chroma extremes and an absent second pixel.
        directed_pairs.push_back(make_pair(8'd0,   8'd0,   8'd128, 8'd128, 1'b1));
        directed_pairs.push_back(make_pair(8'd255, 8'd255, 8'd128, 8'd128, 1'b1));
        directed_pairs.push_back(make_pair(8'd100, 8'd200, 8'd128, 8'd128, 1'b1));
        directed_pairs.push_back(make_pair(8'd0,   8'd255, 8'd0,   8'd0,   1'b1));
        directed_pairs.push_back(make_pair(8'd255, 8'd0,   8'd255, 8'd255, 1'b1));
        directed_pairs.push_back(make_pair(8'd0,   8'd255, 8'd255, 8'd0,   1'b1));
        directed_pairs.push_back(make_pair(8'd255, 8'd0,   8'd0,   8'd255, 1'b1));
        directed_pairs.push_back(make_pair(8'd128, 8'd128, 8'd0,   8'd0,   1'b1));
        directed_pairs.push_back(make_pair(8'd128, 8'd128, 8'd255, 8'd255, 1'b1));
        directed_pairs.push_back(make_pair(8'd128, 8'd128, 8'd255, 8'd0,   1'b1));
        directed_pairs.push_back(make_pair(8'd128, 8'd128, 8'd0,   8'd255, 1'b1));
        directed_pairs.push_back(make_pair(8'd16,  8'd235, 8'd127, 8'd129, 1'b1));
        directed_pairs.push_back(make_pair(8'd200, 8'd255, 8'd90,  8'd170, 1'b0));
        directed_pairs.push_back(make_pair(8'd0,   8'd255, 8'd255, 8'd255, 1'b0));
        directed_pairs.push_back(make_pair(8'd255, 8'd170, 8'd85,  8'd85,  1'b0));
        directed_pairs.push_back(make_pair(8'd1,   8'd254, 8'd1,   8'd254, 1'b1));
        directed_pairs.push_back(make_pair(8'd254, 8'd1,   8'd254, 8'd1,   1'b1));
        directed_pairs.push_back(make_pair(8'd85,  8'd170, 8'd170, 8'd85,  1'b1));
        foreach (directed_pairs[idx]) begin
            send_pair(directed_pairs[idx]);
        end
        idle_cycles(3);

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n < RANDOM_PAIRS - CALM_TAIL && $urandom_range(0, 5) == 0) begin
                idle_cycles($urandom_range(1, 13));
            end
            send_pair(random_pair());
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (pixel_board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pixel_board.pending() != 0) begin
            pixel_board.report_mismatch("results never arrived", 32'(pixel_board.pending()),
                                        32'd0);
        end

        if (pixel_board.fail_count == 0) begin
            $display("ycbcr420_pair_to_argb32_core verification clean");
        end else begin
            $display("ycbcr420_pair_to_argb32_core verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/y420argb_pkg.sv
rtl/y420argb_offset.sv
rtl/y420argb_pack.sv
rtl/ycbcr420_pair_to_argb32_core.sv
dv/tb_ycbcr420_pair_to_argb32_core.sv
